// ===== design/krx_pkg.sv =====
// ----------------------------------------------------------------------------
// krx_pkg
// Shared types and constants for the K-line response frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none

package krx_pkg;

  localparam logic [7:0] FMT_LONG   = 8'h80;
  localparam logic [7:0] FMT_SHORT  = 8'h81;
  localparam logic [7:0] LEN_MASK   = 8'h3f;
  localparam logic [7:0] SVC_NEG    = 8'h7f;
  localparam logic [7:0] NRC_REPEAT = 8'h21;

  localparam logic [7:0] NRC_GENERAL_REJECT = 8'h10;
  localparam logic [7:0] NRC_NOT_SUPPORTED  = 8'h11;
  localparam logic [7:0] NRC_SUBFN_INVALID  = 8'h12;
  localparam logic [7:0] NRC_COND_NOT_OK    = 8'h22;
  localparam logic [7:0] NRC_PENDING        = 8'h78;

  localparam int CNT_W = 9;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [7:0] ADDR_SERVICE = 8'd0;
  localparam logic [7:0] ADDR_CODE    = 8'd2;

  typedef enum logic [1:0] {
    REPORT_NONE     = 2'd0,
    REPORT_POSITIVE = 2'd1,
    REPORT_REPEAT   = 2'd2
  } report_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
    logic       single_packet;
  } request_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_addr;
    logic [7:0] store_data;
    logic       frame_done;
    report_t    report;
    logic       negative;
    logic       rx_disable;
  } result_t;

  function automatic logic is_negative_code(input logic [7:0] c);
    is_negative_code = (c == NRC_GENERAL_REJECT) || (c == NRC_NOT_SUPPORTED) ||
                       (c == NRC_SUBFN_INVALID)  || (c == NRC_REPEAT) ||
                       (c == NRC_COND_NOT_OK)    || (c == NRC_PENDING);
  endfunction

endpackage

`default_nettype wire

// ===== design/krx_parse.sv =====
// ----------------------------------------------------------------------------
// krx_parse
// Header decoder and frame state: updates the parser state for one request
// and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module krx_parse (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire krx_pkg::request_t  req,
  output krx_pkg::result_t        res
);

  logic [krx_pkg::CNT_W-1:0] byte_count, byte_count_next;
  logic [krx_pkg::CNT_W-1:0] write_offset, write_offset_next;
  logic [7:0]                header_format, header_format_next;
  logic [7:0]                frame_length, frame_length_next;
  logic [7:0]                service_byte, service_byte_next;
  logic [7:0]                code_byte, code_byte_next;
  logic                      single_mode, single_mode_next;

  logic [krx_pkg::CNT_W-1:0] wo_inc;
  logic [krx_pkg::CNT_W-1:0] end_mark;
  logic                      emit;
  logic                      done;
  logic                      neg;

  always_comb begin
    byte_count_next    = byte_count;
    write_offset_next  = write_offset;
    header_format_next = header_format;
    frame_length_next  = frame_length;
    service_byte_next  = service_byte;
    code_byte_next     = code_byte;
    single_mode_next   = single_mode;
    wo_inc             = write_offset + 1'b1;
    end_mark           = {1'b0, frame_length} + 1'b1;
    emit               = 1'b0;
    done               = 1'b0;
    neg                = 1'b0;
    res                = '0;

    if (req.kind) begin
      byte_count_next   = '0;
      write_offset_next = '0;
      single_mode_next  = req.single_packet;
    end else begin
      write_offset_next = wo_inc;
      if (byte_count != krx_pkg::CNT_MAX) begin
        byte_count_next = byte_count + 1'b1;
      end

      priority if (byte_count == 'd0) begin
        if (req.rx_byte >= krx_pkg::FMT_SHORT) begin
          header_format_next = req.rx_byte;
          frame_length_next  = req.rx_byte & krx_pkg::LEN_MASK;
        end else if (req.rx_byte == krx_pkg::FMT_LONG) begin
          header_format_next = req.rx_byte;
          frame_length_next  = 8'hff;
        end else begin
          write_offset_next = '0;
          byte_count_next   = '0;
        end
      end else if (byte_count == 'd1 || byte_count == 'd2) begin
        if (header_format != krx_pkg::FMT_LONG) begin
          write_offset_next = '0;
        end
      end else if (byte_count == 'd3) begin
        if (header_format == krx_pkg::FMT_LONG) begin
          frame_length_next = req.rx_byte;
          write_offset_next = '0;
        end else begin
          emit = 1'b1;
        end
      end else begin
        emit = 1'b1;
      end

      if (emit) begin
        res.store_valid = 1'b1;
        res.store_addr  = write_offset[7:0];
        res.store_data  = req.rx_byte;
        if (write_offset[7:0] == krx_pkg::ADDR_SERVICE) begin
          service_byte_next = req.rx_byte;
        end
        if (write_offset[7:0] == krx_pkg::ADDR_CODE) begin
          code_byte_next = req.rx_byte;
        end
      end

      done = (byte_count >= 'd4) && (wo_inc == end_mark);
      if (done) begin
        write_offset_next = '0;
        byte_count_next   = '0;
        neg = (service_byte_next == krx_pkg::SVC_NEG) &&
              krx_pkg::is_negative_code(code_byte_next);
        res.frame_done = 1'b1;
        res.rx_disable = single_mode;
        res.negative   = neg;
        if (!neg) begin
          res.report = krx_pkg::REPORT_POSITIVE;
        end else if (code_byte_next == krx_pkg::NRC_REPEAT) begin
          res.report = krx_pkg::REPORT_REPEAT;
        end else begin
          res.report = krx_pkg::REPORT_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= '0;
      write_offset  <= '0;
      header_format <= '0;
      frame_length  <= '0;
      service_byte  <= '0;
      code_byte     <= '0;
      single_mode   <= 1'b0;
    end else if (advance) begin
      byte_count    <= byte_count_next;
      write_offset  <= write_offset_next;
      header_format <= header_format_next;
      frame_length  <= frame_length_next;
      service_byte  <= service_byte_next;
      code_byte     <= code_byte_next;
      single_mode   <= single_mode_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/kline_response_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// kline_response_frame_receiver
// KWP2000 response frame receiver: decodes the header of bytes from the
// K-line and emits payload/checksum buffer writes and frame status.
//
// channel  direction  handshake            payload
// in       request    in_valid / in_stall  kind, rx_byte, single_packet
// out      result     out_valid / out_stall store_*, frame_done, report,
//                                          negative, rx_disable
//
// One request per cycle sustained while the result is not stalled; each request
// goes through the input register, then decode into the result register.
// Reset clears the frame state and both stage valids.
// A stalled result holds the result register; the input register keeps
// accepting while it is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module kline_response_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       kind,
  input  wire logic [7:0] rx_byte,
  input  wire logic       single_packet,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            store_valid,
  output logic [7:0]      store_addr,
  output logic [7:0]      store_data,
  output logic            frame_done,
  output logic [1:0]      report,
  output logic            negative,
  output logic            rx_disable
);

  logic              req_valid;
  krx_pkg::request_t req;
  krx_pkg::result_t  res_comb;
  krx_pkg::result_t  res;
  logic              advance;
  logic              out_free;

  assign out_free = !out_valid || !out_stall;
  assign advance  = req_valid && out_free;
  assign in_stall = req_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!in_stall) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req.kind          <= kind;
      req.rx_byte       <= rx_byte;
      req.single_packet <= single_packet;
    end
  end

  krx_parse u_parse (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .req     (req),
    .res     (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_comb;
    end
  end

  assign store_valid = res.store_valid;
  assign store_addr  = res.store_addr;
  assign store_data  = res.store_data;
  assign frame_done  = res.frame_done;
  assign report      = res.report;
  assign negative    = res.negative;
  assign rx_disable  = res.rx_disable;

endmodule

`default_nettype wire
